// File: rtl/core/esfd_pkg.sv
// shared types, codes and crc helper for the event stream frame decoder
package esfd_pkg;

  localparam int unsigned PreludeBytes = 12;
  localparam int unsigned MinMsgBytes  = 16;
  localparam logic [31:0] CrcPoly      = 32'hEDB88320;
  localparam logic [31:0] CrcInit      = 32'hFFFFFFFF;
  localparam logic [31:0] MaxLenReset  = 32'd16777216;

  typedef enum logic [2:0] {
    KIND_PRELUDE = 3'd0,
    KIND_NLEN    = 3'd1,
    KIND_NAME    = 3'd2,
    KIND_TYPE    = 3'd3,
    KIND_VALUE   = 3'd4,
    KIND_PAYLOAD = 3'd5,
    KIND_CRC     = 3'd6,
    KIND_DISCARD = 3'd7
  } byte_kind_e;

  typedef enum logic [2:0] {
    ST_BUSY     = 3'd0,
    ST_OK       = 3'd1,
    ST_BAD_LEN  = 3'd2,
    ST_PRE_CRC  = 3'd3,
    ST_MSG_CRC  = 3'd4,
    ST_BAD_HDR  = 3'd5,
    ST_UNUSED_A = 3'd6,
    ST_UNUSED_B = 3'd7
  } status_e;

  // header value type codes
  localparam logic [3:0] VT_TRUE   = 4'd0;
  localparam logic [3:0] VT_FALSE  = 4'd1;
  localparam logic [3:0] VT_INT8   = 4'd2;
  localparam logic [3:0] VT_INT16  = 4'd3;
  localparam logic [3:0] VT_INT32  = 4'd4;
  localparam logic [3:0] VT_INT64  = 4'd5;
  localparam logic [3:0] VT_BYTES  = 4'd6;
  localparam logic [3:0] VT_STRING = 4'd7;
  localparam logic [3:0] VT_TSTAMP = 4'd8;
  localparam logic [3:0] VT_UUID   = 4'd9;

  // error flag bits
  localparam int unsigned ErrHdr   = 0;
  localparam int unsigned ErrGuard = 1;
  localparam int unsigned ErrPre   = 2;

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

// File: rtl/core/event_stream_frame_decoder_top.sv
// event stream frame decoder: per-byte prelude, header and crc checking with a result register
//
// Takes one byte per cycle and gives one tagged result per byte, in the cycle
// after the transfer, at a sustained rate of one byte per clock. All parsing
// and the crc32 byte update sit between the input transfer and the result
// register, so a new byte can enter in the same cycle as the previous result
// is taken; while a result is held by out_stall_i the input is stalled. A
// length or prelude crc error halts the block until reset; halted bytes come
// out as discarded. max_message_length is written through cfg_we_i/cfg_wdata_i;
// the user must write it only while no byte is in flight; the block does not enforce this.
module event_stream_frame_decoder_top
  import esfd_pkg::*;
#(
  parameter int unsigned MAX_HEADERS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         byte_out_o,
  output logic [2:0]         byte_kind_o,
  output logic [5:0]         header_index_o,
  output logic [3:0]         val_code_o,
  output logic               value_done_o,
  output logic signed [63:0] val_int_o,
  output logic               message_end_o,
  output logic [2:0]         status_o,
  output logic               hdr_overflow_o
);

  typedef enum logic [2:0] {
    PH_NLEN  = 3'd0,
    PH_NAME  = 3'd1,
    PH_TYPE  = 3'd2,
    PH_VAL   = 3'd3,
    PH_LENHI = 3'd4,
    PH_LENLO = 3'd5,
    PH_ERR   = 3'd6
  } phase_e;

  logic        accept;
  logic [31:0] max_len_q;
  logic        halted_q, halted_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] tot_q, tot_d;
  logic [31:0] hl_q, hl_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] cap_q, cap_d;
  phase_e      phase_q, phase_d;
  logic [15:0] rem_q, rem_d;
  logic [3:0]  type_q, type_d;
  logic [63:0] acc_q, acc_d;
  logic [5:0]  hcnt_q, hcnt_d;
  logic [2:0]  flags_q, flags_d;
  logic        trunc_q, trunc_d;

  logic        out_valid_q;
  logic [7:0]  byte_q;
  byte_kind_e  kind_q, kind;
  logic [5:0]  hidx_q, hidx;
  logic [3:0]  vtype_q, vtype;
  logic        vdone_q, vdone;
  logic [63:0] ival_q, ival;
  logic        mend_q, mend;
  status_e     stat_q, stat;
  logic        tout_q, tout;

  logic [31:0] crc_next;
  logic [31:0] hdr_off;
  logic [7:0]  cap_byte;
  logic        fin;

  assign accept     = in_valid_i & ~in_stall_o;
  assign in_stall_o = out_valid_q & out_stall_i;
  assign crc_next   = crc32_byte(crc_q, data_byte_i);
  assign hdr_off    = pos_q - 32'(PreludeBytes);

  always_comb begin
    halted_d = halted_q;
    pos_d    = pos_q;
    tot_d    = tot_q;
    hl_d     = hl_q;
    crc_d    = crc_q;
    cap_d    = cap_q;
    phase_d  = phase_q;
    rem_d    = rem_q;
    type_d   = type_q;
    acc_d    = acc_q;
    hcnt_d   = hcnt_q;
    flags_d  = flags_q;
    trunc_d  = trunc_q;
    kind     = KIND_PRELUDE;
    hidx     = '0;
    vtype    = '0;
    vdone    = 1'b0;
    ival     = '0;
    mend     = 1'b0;
    stat     = ST_BUSY;
    tout     = 1'b0;
    fin      = 1'b0;
    cap_byte = '0;

    if (halted_q) begin
      kind = KIND_DISCARD;
    end else if (pos_q < 32'(PreludeBytes)) begin
      crc_d = crc_next;
      pos_d = pos_q + 32'd1;
      if (pos_q < 32'd4) begin
        tot_d = {tot_q[23:0], data_byte_i};
        if (pos_q == 32'd3 && (tot_d < 32'(MinMsgBytes) || tot_d > max_len_q)) begin
          mend     = 1'b1;
          stat     = ST_BAD_LEN;
          halted_d = 1'b1;
        end
      end else if (pos_q < 32'd8) begin
        hl_d = {hl_q[23:0], data_byte_i};
        if (pos_q == 32'd7) begin
          cap_d = ~crc_next;
          if ({1'b0, hl_d} + 33'(MinMsgBytes) > {1'b0, tot_q}) begin
            flags_d[ErrGuard] = 1'b1;
          end
        end
      end else begin
        case (pos_q[1:0])
          2'd0:    cap_byte = cap_q[31:24];
          2'd1:    cap_byte = cap_q[23:16];
          2'd2:    cap_byte = cap_q[15:8];
          default: cap_byte = cap_q[7:0];
        endcase
        if (cap_byte != data_byte_i) begin
          flags_d[ErrPre] = 1'b1;
        end
        if (pos_q == 32'd11 && flags_d[ErrPre]) begin
          mend     = 1'b1;
          stat     = ST_PRE_CRC;
          halted_d = 1'b1;
        end
      end
      tout = trunc_q & ~halted_d;
    end else if ({1'b0, pos_q} + 33'd4 >= {1'b0, tot_q}) begin
      kind  = KIND_CRC;
      cap_d = {cap_q[23:0], data_byte_i};
      if ({1'b0, pos_q} + 33'd1 >= {1'b0, tot_q}) begin
        mend = 1'b1;
        if (~crc_q != cap_d) begin
          stat = ST_MSG_CRC;
        end else if (flags_q[ErrGuard] | flags_q[ErrHdr]) begin
          stat = ST_BAD_HDR;
        end else begin
          stat = ST_OK;
        end
        tout    = trunc_q;
        pos_d   = '0;
        tot_d   = '0;
        hl_d    = '0;
        crc_d   = CrcInit;
        cap_d   = '0;
        phase_d = PH_NLEN;
        rem_d   = '0;
        type_d  = '0;
        acc_d   = '0;
        hcnt_d  = '0;
        flags_d = '0;
        trunc_d = 1'b0;
      end else begin
        pos_d = pos_q + 32'd1;
      end
    end else begin
      crc_d = crc_next;
      pos_d = pos_q + 32'd1;
      if (flags_q[ErrGuard]) begin
        kind = KIND_DISCARD;
      end else if (hdr_off < hl_q) begin
        if (phase_q == PH_ERR) begin
          kind = KIND_DISCARD;
        end else begin
          hidx = hcnt_q;
          case (phase_q)
            PH_NLEN: begin
              kind    = KIND_NLEN;
              rem_d   = {8'd0, data_byte_i};
              phase_d = (data_byte_i != 8'd0) ? PH_NAME : PH_TYPE;
            end
            PH_NAME: begin
              kind  = KIND_NAME;
              rem_d = rem_q - 16'd1;
              if (rem_d == 16'd0) begin
                phase_d = PH_TYPE;
              end
            end
            PH_TYPE: begin
              kind   = KIND_TYPE;
              type_d = data_byte_i[3:0];
              vtype  = data_byte_i[3:0];
              acc_d  = '0;
              if (data_byte_i > 8'd9) begin
                flags_d[ErrHdr] = 1'b1;
                phase_d         = PH_ERR;
              end else begin
                case (data_byte_i[3:0])
                  VT_TRUE, VT_FALSE: fin = 1'b1;
                  VT_INT8: begin
                    rem_d   = 16'd1;
                    phase_d = PH_VAL;
                  end
                  VT_INT16: begin
                    rem_d   = 16'd2;
                    phase_d = PH_VAL;
                  end
                  VT_INT32: begin
                    rem_d   = 16'd4;
                    phase_d = PH_VAL;
                  end
                  VT_INT64, VT_TSTAMP: begin
                    rem_d   = 16'd8;
                    phase_d = PH_VAL;
                  end
                  VT_BYTES, VT_STRING: phase_d = PH_LENHI;
                  default: begin
                    rem_d   = 16'd16;
                    phase_d = PH_VAL;
                  end
                endcase
              end
            end
            PH_LENHI: begin
              kind    = KIND_VALUE;
              vtype   = type_q;
              rem_d   = {data_byte_i, 8'd0};
              phase_d = PH_LENLO;
            end
            PH_LENLO: begin
              kind  = KIND_VALUE;
              vtype = type_q;
              rem_d = rem_q | {8'd0, data_byte_i};
              if (rem_d == 16'd0) begin
                fin = 1'b1;
              end else begin
                phase_d = PH_VAL;
              end
            end
            default: begin
              kind  = KIND_VALUE;
              vtype = type_q;
              acc_d = {acc_q[55:0], data_byte_i};
              rem_d = rem_q - 16'd1;
              if (rem_d == 16'd0) begin
                fin = 1'b1;
              end
            end
          endcase

          if (fin) begin
            vdone = 1'b1;
            case (type_d)
              VT_TRUE:             ival = 64'd1;
              VT_INT8:             ival = {{56{acc_d[7]}}, acc_d[7:0]};
              VT_INT16:            ival = {{48{acc_d[15]}}, acc_d[15:0]};
              VT_INT32:            ival = {{32{acc_d[31]}}, acc_d[31:0]};
              VT_INT64, VT_TSTAMP: ival = acc_d;
              default:             ival = '0;
            endcase
            if (hcnt_q < 6'(MAX_HEADERS)) begin
              hcnt_d = hcnt_q + 6'd1;
            end else begin
              trunc_d = 1'b1;
            end
            phase_d = PH_NLEN;
          end

          // header block ends inside a header
          if ({1'b0, hdr_off} + 33'd1 == {1'b0, hl_q}
              && phase_d != PH_NLEN && phase_d != PH_ERR) begin
            flags_d[ErrHdr] = 1'b1;
            phase_d         = PH_ERR;
          end
        end
      end else begin
        kind = KIND_PAYLOAD;
      end
      tout = trunc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q   <= MaxLenReset;
      halted_q    <= 1'b0;
      pos_q       <= '0;
      tot_q       <= '0;
      hl_q        <= '0;
      crc_q       <= CrcInit;
      cap_q       <= '0;
      phase_q     <= PH_NLEN;
      rem_q       <= '0;
      type_q      <= '0;
      acc_q       <= '0;
      hcnt_q      <= '0;
      flags_q     <= '0;
      trunc_q     <= 1'b0;
      out_valid_q <= 1'b0;
      byte_q      <= '0;
      kind_q      <= KIND_PRELUDE;
      hidx_q      <= '0;
      vtype_q     <= '0;
      vdone_q     <= 1'b0;
      ival_q      <= '0;
      mend_q      <= 1'b0;
      stat_q      <= ST_BUSY;
      tout_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
      if (accept) begin
        halted_q <= halted_d;
        pos_q    <= pos_d;
        tot_q    <= tot_d;
        hl_q     <= hl_d;
        crc_q    <= crc_d;
        cap_q    <= cap_d;
        phase_q  <= phase_d;
        rem_q    <= rem_d;
        type_q   <= type_d;
        acc_q    <= acc_d;
        hcnt_q   <= hcnt_d;
        flags_q  <= flags_d;
        trunc_q  <= trunc_d;
        // result register, loaded on each input transfer
        byte_q   <= data_byte_i;
        kind_q   <= kind;
        hidx_q   <= hidx;
        vtype_q  <= vtype;
        vdone_q  <= vdone;
        ival_q   <= ival;
        mend_q   <= mend;
        stat_q   <= stat;
        tout_q   <= tout;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign byte_out_o     = byte_q;
  assign byte_kind_o    = kind_q;
  assign header_index_o = hidx_q;
  assign val_code_o     = vtype_q;
  assign value_done_o   = vdone_q;
  assign val_int_o      = ival_q;
  assign message_end_o  = mend_q;
  assign status_o       = stat_q;
  assign hdr_overflow_o = tout_q;

endmodule

// File: sim/tb_event_stream_frame_decoder_top.sv
// self-checking testbench for the event stream frame decoder top level
module tb_event_stream_frame_decoder_top;
  import esfd_pkg::*;

  localparam int unsigned MaxHeaders = 32;
  localparam int unsigned CycleLimit = 400000;

  typedef enum logic [2:0] {
    PH_NLEN, PH_NAME, PH_TYPE, PH_VAL, PH_LENHI, PH_LENLO, PH_ERR
  } hdr_phase_e;

  typedef enum int unsigned {
    MK_EMPTY, MK_ALL_TYPES, MK_OK, MK_MSG_CRC, MK_BAD_TYPE, MK_OVERRUN, MK_GUARD,
    MK_NOISE, MK_TRUNC
  } msg_kind_e;

  typedef enum int unsigned {HALT_SHORT, HALT_LONG, HALT_PRE_CRC} halt_e;

  typedef struct packed {
    logic [7:0]         data;
    byte_kind_e         kind;
    logic [5:0]         hidx;
    logic [3:0]         vtype;
    logic               vdone;
    logic signed [63:0] ival;
    logic               msg_end;
    status_e            status;
    logic               trunc;
  } frame_result_t;

  class decode_scoreboard;
    frame_result_t pending_results[$];
    int unsigned   mismatches;
    logic [31:0]   max_len;
    logic [31:0]   byte_pos;
    logic [31:0]   msg_len;
    logic [31:0]   hdr_len;
    logic [31:0]   crc_acc;
    logic [31:0]   crc_word;
    hdr_phase_e    phase;
    logic [15:0]   field_left;
    logic [3:0]    val_type;
    logic [63:0]   val_acc;
    logic [5:0]    hdr_count;
    logic [2:0]    err_bits;
    bit            stopped;
    bit            over_cap;

    function new();
      max_len    = MaxLenReset;
      stopped    = 1'b0;
      mismatches = 0;
      clear_message();
    endfunction

    static function logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] x;
      x = c ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
        x = x[0] ? ((x >> 1) ^ CrcPoly) : (x >> 1);
      end
      return x;
    endfunction

    function void clear_message();
      byte_pos   = '0;
      msg_len    = '0;
      hdr_len    = '0;
      crc_acc    = CrcInit;
      crc_word   = '0;
      phase      = PH_NLEN;
      field_left = '0;
      val_type   = '0;
      val_acc    = '0;
      hdr_count  = '0;
      err_bits   = '0;
      over_cap   = 1'b0;
    endfunction

    function void finish_value(inout frame_result_t r);
      logic [63:0] v;
      case (val_type)
        VT_TRUE:             v = 64'd1;
        VT_INT8:             v = {{56{val_acc[7]}}, val_acc[7:0]};
        VT_INT16:            v = {{48{val_acc[15]}}, val_acc[15:0]};
        VT_INT32:            v = {{32{val_acc[31]}}, val_acc[31:0]};
        VT_INT64, VT_TSTAMP: v = val_acc;
        default:             v = 64'd0;
      endcase
      r.vdone = 1'b1;
      r.ival  = v;
      if (hdr_count < MaxHeaders) hdr_count = hdr_count + 6'd1;
      else over_cap = 1'b1;
      phase = PH_NLEN;
    endfunction

    function void step_header(input logic [7:0] b, inout frame_result_t r);
      if (phase == PH_ERR) begin
        r.kind = KIND_DISCARD;
        return;
      end
      r.hidx = hdr_count;
      case (phase)
        PH_NLEN: begin
          r.kind     = KIND_NLEN;
          field_left = {8'd0, b};
          phase      = (b != 8'd0) ? PH_NAME : PH_TYPE;
        end
        PH_NAME: begin
          r.kind     = KIND_NAME;
          field_left = field_left - 16'd1;
          if (field_left == 16'd0) phase = PH_TYPE;
        end
        PH_TYPE: begin
          r.kind   = KIND_TYPE;
          val_type = b[3:0];
          r.vtype  = val_type;
          val_acc  = '0;
          if (b > 8'd9) begin
            err_bits[ErrHdr] = 1'b1;
            phase = PH_ERR;
          end else begin
            case (b[3:0])
              VT_TRUE, VT_FALSE:   finish_value(r);
              VT_INT8:             begin field_left = 16'd1; phase = PH_VAL; end
              VT_INT16:            begin field_left = 16'd2; phase = PH_VAL; end
              VT_INT32:            begin field_left = 16'd4; phase = PH_VAL; end
              VT_INT64, VT_TSTAMP: begin field_left = 16'd8; phase = PH_VAL; end
              VT_BYTES, VT_STRING: phase = PH_LENHI;
              default:             begin field_left = 16'd16; phase = PH_VAL; end
            endcase
          end
        end
        PH_LENHI: begin
          r.kind     = KIND_VALUE;
          r.vtype    = val_type;
          field_left = {b, 8'd0};
          phase      = PH_LENLO;
        end
        PH_LENLO: begin
          r.kind     = KIND_VALUE;
          r.vtype    = val_type;
          field_left = field_left | {8'd0, b};
          if (field_left == 16'd0) finish_value(r);
          else phase = PH_VAL;
        end
        default: begin
          r.kind     = KIND_VALUE;
          r.vtype    = val_type;
          val_acc    = {val_acc[55:0], b};
          field_left = field_left - 16'd1;
          if (field_left == 16'd0) finish_value(r);
        end
      endcase
    endfunction

    // one accepted input byte gives exactly one expected result
    function void note_byte(input logic [7:0] b);
      frame_result_t r;
      logic [31:0]   p;
      r      = '0;
      r.data = b;
      r.kind = KIND_PRELUDE;
      p      = byte_pos;
      if (stopped) begin
        r.kind = KIND_DISCARD;
      end else if (p < PreludeBytes) begin
        crc_acc  = crc_next(crc_acc, b);
        byte_pos = p + 32'd1;
        if (p < 4) begin
          msg_len = {msg_len[23:0], b};
          if (p == 3 && (msg_len < MinMsgBytes || msg_len > max_len)) begin
            r.msg_end = 1'b1;
            r.status  = ST_BAD_LEN;
            stopped   = 1'b1;
          end
        end else if (p < 8) begin
          hdr_len = {hdr_len[23:0], b};
          if (p == 7) begin
            crc_word = ~crc_acc;
            if ({1'b0, hdr_len} + 33'd16 > {1'b0, msg_len}) err_bits[ErrGuard] = 1'b1;
          end
        end else begin
          if (((crc_word >> ((11 - p) * 8)) & 32'hFF) != {24'd0, b}) err_bits[ErrPre] = 1'b1;
          if (p == 11 && err_bits[ErrPre]) begin
            r.msg_end = 1'b1;
            r.status  = ST_PRE_CRC;
            stopped   = 1'b1;
          end
        end
      end else if ({1'b0, p} + 33'd4 >= {1'b0, msg_len}) begin
        r.kind   = KIND_CRC;
        crc_word = {crc_word[23:0], b};
        if ({1'b0, p} + 33'd1 >= {1'b0, msg_len}) begin
          r.msg_end = 1'b1;
          if (~crc_acc != crc_word) r.status = ST_MSG_CRC;
          else if (err_bits[ErrGuard] || err_bits[ErrHdr]) r.status = ST_BAD_HDR;
          else r.status = ST_OK;
          r.trunc = over_cap;
          clear_message();
        end else begin
          byte_pos = p + 32'd1;
        end
      end else begin
        crc_acc  = crc_next(crc_acc, b);
        byte_pos = p + 32'd1;
        if (err_bits[ErrGuard]) begin
          r.kind = KIND_DISCARD;
        end else if (p - PreludeBytes < hdr_len) begin
          step_header(b, r);
          if ({1'b0, p - PreludeBytes} + 33'd1 == {1'b0, hdr_len}
              && phase != PH_NLEN && phase != PH_ERR) begin
            err_bits[ErrHdr] = 1'b1;
            phase = PH_ERR;
          end
        end else begin
          r.kind = KIND_PAYLOAD;
        end
      end
      if (r.kind != KIND_CRC && !stopped) r.trunc = over_cap;
      if (r.kind == KIND_DISCARD && stopped) begin
        r      = '0;
        r.data = b;
        r.kind = KIND_DISCARD;
      end
      pending_results.push_back(r);
    endfunction

    function void compare(input string what, input logic [63:0] want, input logic [63:0] got);
      if (got !== want) begin
        $display("%0t %s: expected %0h, got %0h", $time, what, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(input frame_result_t got);
      frame_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t unexpected transfer: expected none, got byte %0h", $time, got.data);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      compare("byte_out", 64'(want.data), 64'(got.data));
      compare("byte_kind", 64'(want.kind), 64'(got.kind));
      compare("header_index", 64'(want.hidx), 64'(got.hidx));
      compare("val_code", 64'(want.vtype), 64'(got.vtype));
      compare("value_done", 64'(want.vdone), 64'(got.vdone));
      compare("val_int", want.ival, got.ival);
      compare("message_end", 64'(want.msg_end), 64'(got.msg_end));
      compare("status", 64'(want.status), 64'(got.status));
      compare("hdr_overflow", 64'(want.trunc), 64'(got.trunc));
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [31:0]        cfg_wdata_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [7:0]         data_byte_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [7:0]         byte_out_o;
  logic [2:0]         byte_kind_o;
  logic [5:0]         header_index_o;
  logic [3:0]         val_code_o;
  logic               value_done_o;
  logic signed [63:0] val_int_o;
  logic               message_end_o;
  logic [2:0]         status_o;
  logic               hdr_overflow_o;

  decode_scoreboard sb;
  frame_result_t    observed;
  logic [7:0]       body_buf[$];
  logic [7:0]       msg_buf[$];
  int unsigned      send_idle;
  int unsigned      recv_idle;
  int unsigned      bytes_sent;
  int unsigned      cycle_count = 0;
  bit               holdoff_req = 1'b0;

  event_stream_frame_decoder_top #(
    .MAX_HEADERS(MaxHeaders)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .byte_out_o    (byte_out_o),
    .byte_kind_o   (byte_kind_o),
    .header_index_o(header_index_o),
    .val_code_o    (val_code_o),
    .value_done_o  (value_done_o),
    .val_int_o     (val_int_o),
    .message_end_o (message_end_o),
    .status_o      (status_o),
    .hdr_overflow_o(hdr_overflow_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_byte(data_byte_i);
      if (out_valid_o && !out_stall_i) begin
        observed.data    = byte_out_o;
        observed.kind    = byte_kind_e'(byte_kind_o);
        observed.hidx    = header_index_o;
        observed.vtype   = val_code_o;
        observed.vdone   = value_done_o;
        observed.ival    = val_int_o;
        observed.msg_end = message_end_o;
        observed.status  = status_e'(status_o);
        observed.trunc   = hdr_overflow_o;
        sb.check_result(observed);
      end
    end
  end

  // receiver side, with an occasional long hold-off
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        repeat (60) begin
          out_stall_i <= 1'b1;
          @(posedge clk_i);
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle);
    end
  end

  function automatic void push_word(input logic [31:0] w);
    msg_buf.push_back(w[31:24]);
    msg_buf.push_back(w[23:16]);
    msg_buf.push_back(w[15:8]);
    msg_buf.push_back(w[7:0]);
  endfunction

  function automatic void append_header(input logic [3:0] vt);
    int unsigned nlen;
    int unsigned vlen;
    nlen = $urandom_range(3);
    body_buf.push_back(8'(nlen));
    repeat (nlen) body_buf.push_back(8'($urandom));
    body_buf.push_back({4'd0, vt});
    case (vt)
      VT_INT8:             vlen = 1;
      VT_INT16:            vlen = 2;
      VT_INT32:            vlen = 4;
      VT_INT64, VT_TSTAMP: vlen = 8;
      VT_UUID:             vlen = 16;
      VT_BYTES, VT_STRING: begin
        vlen = $urandom_range(3);
        body_buf.push_back(8'(vlen >> 8));
        body_buf.push_back(8'(vlen));
      end
      default:             vlen = 0;
    endcase
    repeat (vlen) body_buf.push_back(8'($urandom));
  endfunction

  function automatic msg_kind_e pick_kind();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return MK_OK;
    if (r < 60) return MK_MSG_CRC;
    if (r < 68) return MK_BAD_TYPE;
    if (r < 76) return MK_OVERRUN;
    if (r < 84) return MK_GUARD;
    if (r < 94) return MK_NOISE;
    return MK_TRUNC;
  endfunction

  function automatic void build_message(input msg_kind_e kind, input logic [31:0] limit,
                                        input bit exact);
    int unsigned start;
    logic [31:0] hlen;
    logic [31:0] crc;
    body_buf.delete();
    msg_buf.delete();
    hlen = '0;
    case (kind)
      MK_EMPTY: ;
      MK_ALL_TYPES: begin
        for (int t = 0; t < 10; t++) append_header(4'(t));
        hlen = body_buf.size();
      end
      MK_BAD_TYPE: begin
        repeat ($urandom_range(2)) append_header(4'($urandom_range(9)));
        body_buf.push_back(8'd0);
        body_buf.push_back(8'($urandom_range(255, 10)));
        repeat ($urandom_range(3)) body_buf.push_back(8'($urandom));
        hlen = body_buf.size();
      end
      MK_OVERRUN: begin
        repeat ($urandom_range(2)) append_header(4'($urandom_range(9)));
        start = body_buf.size();
        append_header(4'($urandom_range(9)));
        hlen = start + $urandom_range(body_buf.size() - start - 1, 1);
      end
      MK_GUARD: begin
        repeat ($urandom_range(6)) body_buf.push_back(8'($urandom));
        if ($urandom_range(3) == 0) hlen = 32'hFFFFFFFF;
        else hlen = body_buf.size() + $urandom_range(40, 1);
      end
      MK_NOISE: begin
        repeat ($urandom_range(12, 1)) begin
          if ($urandom_range(3) == 0) body_buf.push_back(8'($urandom));
          else body_buf.push_back(8'($urandom_range(10)));
        end
        hlen = body_buf.size();
      end
      MK_TRUNC: begin
        repeat ($urandom_range(35, 33)) begin
          body_buf.push_back(8'd0);
          body_buf.push_back($urandom_range(1) ? {4'd0, VT_TRUE} : {4'd0, VT_FALSE});
        end
        hlen = body_buf.size();
      end
      default: begin
        repeat ($urandom_range(3)) append_header(4'($urandom_range(9)));
        hlen = body_buf.size();
      end
    endcase
    if (kind != MK_GUARD && kind != MK_EMPTY) begin
      repeat ($urandom_range(8)) body_buf.push_back(8'($urandom));
    end
    if (MinMsgBytes + body_buf.size() > limit) begin
      body_buf.delete();
      if (kind != MK_GUARD) hlen = '0;
    end
    if (exact) begin
      while (MinMsgBytes + body_buf.size() < limit) body_buf.push_back(8'($urandom));
    end
    push_word(MinMsgBytes + body_buf.size());
    push_word(hlen);
    crc = CrcInit;
    foreach (msg_buf[i]) crc = decode_scoreboard::crc_next(crc, msg_buf[i]);
    push_word(~crc);
    foreach (body_buf[i]) msg_buf.push_back(body_buf[i]);
    crc = CrcInit;
    foreach (msg_buf[i]) crc = decode_scoreboard::crc_next(crc, msg_buf[i]);
    push_word(~crc);
    if (kind == MK_MSG_CRC) begin
      start = msg_buf.size() - 1 - $urandom_range(3);
      msg_buf[start] = msg_buf[start] ^ 8'($urandom_range(255, 1));
    end
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_frame(input msg_kind_e kind, input bit exact);
    build_message(kind, sb.max_len, exact);
    foreach (msg_buf[i]) send_byte(msg_buf[i]);
    bytes_sent += msg_buf.size();
  endtask

  task automatic run_random(input int unsigned goal);
    bytes_sent = 0;
    while (bytes_sent < goal) send_frame(pick_kind(), 1'b0);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_max_len(input logic [31:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.max_len = v;
  endtask

  // ends the stream with a frame that stops the decoder, then a few discarded bytes
  task automatic send_halting_frame();
    halt_e       which;
    logic [31:0] crc;
    which = halt_e'($urandom_range(2));
    msg_buf.delete();
    case (which)
      HALT_SHORT: push_word($urandom_range(15));
      HALT_LONG:  push_word($urandom_range(32'hFFFFFFFF, sb.max_len + 1));
      default: begin
        push_word(MinMsgBytes);
        push_word(32'd0);
        crc = CrcInit;
        foreach (msg_buf[i]) crc = decode_scoreboard::crc_next(crc, msg_buf[i]);
        crc = ~crc ^ (32'(8'($urandom_range(255, 1))) << (8 * $urandom_range(3)));
        push_word(crc);
      end
    endcase
    repeat (8) msg_buf.push_back(8'($urandom));
    foreach (msg_buf[i]) send_byte(msg_buf[i]);
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    data_byte_i = '0;
    send_idle   = 27;
    recv_idle   = 48;
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_frame(MK_EMPTY, 1'b0);
    send_frame(MK_ALL_TYPES, 1'b0);
    send_frame(MK_BAD_TYPE, 1'b0);
    send_frame(MK_OVERRUN, 1'b0);
    send_frame(MK_GUARD, 1'b0);
    send_frame(MK_MSG_CRC, 1'b0);
    send_frame(MK_NOISE, 1'b0);
    send_frame(MK_TRUNC, 1'b0);
    drain();

    write_max_len(32'hFFFFFFFF);
    send_idle   = 48;
    recv_idle   = 27;
    holdoff_req = 1'b1;
    run_random(40);
    drain();

    write_max_len($urandom_range(64, 40));
    send_idle   = 0;
    recv_idle   = 0;
    holdoff_req = 1'b1;
    send_frame(MK_OK, 1'b1);
    drain();

    // only minimum-size frames fit here
    write_max_len(MinMsgBytes);
    run_random(16);
    send_halting_frame();
    drain();

    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
